// ===== sv/bba_pkg.sv =====
// Shared constants, types and codes of the bitmap block allocator.
package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int IDX_W      = 12;
	localparam int CNT_W      = 13;
	localparam int WORD_W     = 32;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int ROWS       = MAX_BLOCKS / WORD_W;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int ST_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [IDX_W-1:0] RST_FIRST_BLK    = IDX_W'(1);
	localparam logic [CNT_W-1:0] RST_TOTAL_BLOCKS = CNT_W'(4096);
	localparam logic [CNT_W-1:0] RST_FREE_COUNT   = CNT_W'(4095);

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLK    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = CFG_IDX_W'(1);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] first_blk;
		logic [CNT_W-1:0] bound;
		logic             reload;
		logic [CNT_W-1:0] reload_cnt;
	} cfg_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_pos;
	} scan_t;

endpackage

// ===== sv/bba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/bba_scan.sv =====
// Finds the lowest free block of one map word inside the allocatable range.
module bba_scan (
	input  logic [bba_pkg::WORD_W-1:0] word,
	input  logic [bba_pkg::ROW_W-1:0]  row,
	input  logic [bba_pkg::IDX_W-1:0]  first_blk,
	input  logic [bba_pkg::CNT_W-1:0]  bound,
	output bba_pkg::scan_t             res
);
	import bba_pkg::*;

	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] up_mask;
	logic [WORD_W-1:0] cand;

	always_comb begin
		lo_mask = '1;
		up_mask = '1;
		if (row == first_blk[IDX_W-1:BIT_W]) begin
			lo_mask = ~((WORD_W'(1) << first_blk[BIT_W-1:0]) - WORD_W'(1));
		end
		if ({1'b0, row} == bound[CNT_W-1:BIT_W]) begin
			up_mask = (WORD_W'(1) << bound[BIT_W-1:0]) - WORD_W'(1);
		end
		cand = ~word & lo_mask & up_mask;
		res.found   = |cand;
		res.bit_pos = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (cand[j]) begin
				res.bit_pos = BIT_W'(j);
			end
		end
	end

endmodule

// ===== sv/bba_ctrl.sv =====
// Request sequencer: word scan, read-modify-write of the map, counter and response register.
module bba_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::cfg_t                 cfg,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          kind,
	input  logic [bba_pkg::IDX_W-1:0]     block_index,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [bba_pkg::ST_W-1:0]      status,
	output logic [bba_pkg::IDX_W-1:0]     allocated_index,
	output logic [bba_pkg::CNT_W-1:0]     free_count,
	output logic                          ram_we,
	output logic [bba_pkg::ROW_W-1:0]     ram_waddr,
	output logic [bba_pkg::WORD_W-1:0]    ram_wdata,
	output logic [bba_pkg::ROW_W-1:0]     ram_raddr,
	input  logic [bba_pkg::WORD_W-1:0]    ram_rdata
);
	import bba_pkg::*;

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  chk_q, chk_d;
	logic [IDX_W-1:0]  blk_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [ROWS-1:0]   row_vld_q;
	logic              rd_vld_s1;
	logic              rsp_valid_q;
	status_t           status_q, status_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  count_q;
	logic              load_rsp;
	logic              req_ok;
	logic [WORD_W-1:0] word;
	logic [ROW_W:0]    next_row;
	logic              last_row;
	scan_t             scan;

	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_ok    = req_valid && !req_stall;
	assign word      = rd_vld_s1 ? ram_rdata : '0;
	assign next_row  = {1'b0, chk_q} + (ROW_W + 1)'(1);
	assign last_row  = {next_row, BIT_W'(0)} >= cfg.bound;

	bba_scan u_scan (
		.word      (word),
		.row       (chk_q),
		.first_blk (cfg.first_blk),
		.bound     (cfg.bound),
		.res       (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		chk_d     = chk_q;
		cnt_d     = cnt_q;
		load_rsp  = 1'b0;
		status_d  = ST_OK;
		idx_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = chk_q;
		ram_wdata = word;
		ram_raddr = next_row[ROW_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (req_ok) begin
					if (kind == KIND_ALLOC) begin
						ram_raddr = cfg.first_blk[IDX_W-1:BIT_W];
						if (cnt_q == '0) begin
							load_rsp = 1'b1;
							status_d = ST_NO_SPACE;
						end else begin
							chk_d   = cfg.first_blk[IDX_W-1:BIT_W];
							state_d = S_SCAN;
						end
					end else begin
						ram_raddr = block_index[IDX_W-1:BIT_W];
						if (block_index < cfg.first_blk || {1'b0, block_index} >= cfg.bound) begin
							load_rsp = 1'b1;
							status_d = ST_INVALID;
						end else begin
							state_d = S_FREE;
						end
					end
				end
			end
			S_SCAN: begin
				if (scan.found) begin
					ram_we    = 1'b1;
					ram_wdata = word | (WORD_W'(1) << scan.bit_pos);
					cnt_d     = cnt_q - CNT_W'(1);
					load_rsp  = 1'b1;
					idx_d     = {chk_q, scan.bit_pos};
					state_d   = S_IDLE;
				end else if (last_row) begin
					load_rsp = 1'b1;
					status_d = ST_NO_SPACE;
					state_d  = S_IDLE;
				end else begin
					chk_d = next_row[ROW_W-1:0];
				end
			end
			S_FREE: begin
				ram_we    = 1'b1;
				ram_waddr = blk_q[IDX_W-1:BIT_W];
				ram_wdata = word & ~(WORD_W'(1) << blk_q[BIT_W-1:0]);
				if (cnt_q < CNT_W'(MAX_BLOCKS)) begin
					cnt_d = cnt_q + CNT_W'(1);
				end
				load_rsp = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg.reload) begin
			cnt_d = cfg.reload_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= RST_FREE_COUNT;
			row_vld_q   <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q     <= cnt_d;
			rd_vld_s1 <= row_vld_q[ram_raddr];
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_q <= chk_d;
		if (req_ok) begin
			blk_q <= block_index;
		end
		if (load_rsp) begin
			status_q <= status_d;
			idx_q    <= idx_d;
			count_q  <= cnt_d;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign allocated_index = idx_q;
	assign free_count      = count_q;

endmodule

// ===== sv/bitmap_block_allocator.sv =====
// Top level of the bitmap first-fit block allocator: configuration registers, map RAM, sequencer.
//
// Channel   Handshake            Payload
// req       req_valid/req_stall  kind, block_index
// rsp       rsp_valid/rsp_stall  status, allocated_index, free_count
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request at a time. Allocate scans one 32-bit map word at a time from the row of the first
// allocatable block, up to MAX_BLOCKS/32 = 128 words, each read through the registered RAM port.
// Free: read the map word, write it back; out-of-range free and empty allocate answer from idle.
// The map needs no clearing pass after reset: a per-word valid bit makes unwritten words
// read as all free. A stalled response holds and blocks new requests.
module bitmap_block_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              kind,
	input  logic [bba_pkg::IDX_W-1:0]         block_index,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [bba_pkg::ST_W-1:0]          status,
	output logic [bba_pkg::IDX_W-1:0]         allocated_index,
	output logic [bba_pkg::CNT_W-1:0]         free_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bba_pkg::*;

	logic [IDX_W-1:0]  ds_q, ds_d;
	logic [CNT_W-1:0]  total_q, total_d;
	logic [CNT_W-1:0]  bound_d;
	logic              cfg_we;
	cfg_t              cfg;
	logic              ram_we;
	logic [ROW_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ROW_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_comb begin
		ds_d    = ds_q;
		total_d = total_q;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_BLK:    ds_d    = cfg_data[IDX_W-1:0];
				REG_TOTAL_BLOCKS: total_d = cfg_data[CNT_W-1:0];
				default:          ds_d    = ds_q;
			endcase
		end
		bound_d        = (total_d > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_d;
		cfg.reload     = cfg_we;
		cfg.reload_cnt = ({1'b0, ds_d} < bound_d) ? bound_d - {1'b0, ds_d} : '0;
		cfg.first_blk  = ds_q;
		cfg.bound      = (total_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_q    <= RST_FIRST_BLK;
			total_q <= RST_TOTAL_BLOCKS;
		end else begin
			ds_q    <= ds_d;
			total_q <= total_d;
		end
	end

	bba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bba_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.kind            (kind),
		.block_index     (block_index),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.allocated_index (allocated_index),
		.free_count      (free_count),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata)
	);

endmodule

// ===== sv/bba_checker.sv =====
// Port-level checker for the bitmap block allocator, bound to the top level.
module bba_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_stall,
	input logic                              kind,
	input logic [bba_pkg::IDX_W-1:0]         block_index,
	input logic                              rsp_valid,
	input logic                              rsp_stall,
	input logic [bba_pkg::ST_W-1:0]          status,
	input logic [bba_pkg::IDX_W-1:0]         allocated_index,
	input logic [bba_pkg::CNT_W-1:0]         free_count,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bba_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(free_count))
		else $error("stalled response changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_NO_SPACE || status == ST_INVALID))
		else $error("undefined status code");

	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> allocated_index == '0)
		else $error("failed request returned a block index");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> free_count <= CNT_W'(MAX_BLOCKS))
		else $error("free count above block limit");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
